@@ hdl/rgbcc_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbcc_pkg
// Shared types and constants of the RGB color matrix and clamp unit.
// ----------------------------------------------------------------------------
package rgbcc_pkg;

  localparam int unsigned COEF_BITS_DEFAULT = 16;
  localparam int unsigned REG_BITS          = 48;
  localparam int unsigned CHANNEL_BITS      = 8;
  localparam int unsigned NUM_ROWS          = 3;
  localparam int unsigned NUM_COLS          = 3;
  localparam int unsigned UNITY_GAIN        = 1000;
  localparam int unsigned CHANNEL_MAX       = 255;

  // Register indexes on the configuration port.
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t IDX_RED_ROW   = 2'd0;
  localparam cfg_index_t IDX_GREEN_ROW = 2'd1;
  localparam cfg_index_t IDX_BLUE_ROW  = 2'd2;

  // Divide by UNITY_GAIN through a reciprocal. Only the products of sums from zero
  // up to below CLAMP_LIMIT are used, and the quotient stays exact there.
  localparam int unsigned CLAMP_LIMIT  = (CHANNEL_MAX + 1) * UNITY_GAIN;
  localparam int unsigned DIV_IN_BITS  = 18;
  localparam int unsigned RECIP_BITS   = 19;
  localparam int unsigned RECIP_SHIFT  = 28;
  localparam int unsigned RECIP_MULT   = ((1 << RECIP_SHIFT) + UNITY_GAIN - 1) / UNITY_GAIN;
  localparam int unsigned SCALED_BITS  = DIV_IN_BITS + RECIP_BITS;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
  } pixel_out_t;

endpackage

@@ hdl/rgb_color_matrix_clamp_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_color_matrix_clamp_unit
// 3x3 color correction matrix with divide by 1000 and clamp to 0..255.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel (in_valid_i / in_ready_o / in_pixel_i) and
// leave on the out channel (out_valid_o / out_ready_i / out_pixel_o); a
// transfer happens when valid and ready are both high. Each output channel
// is the dot product of one coefficient row with (r,g,b), divided by 1000
// with truncation toward zero and clamped to 0..255.
// Throughput is one pixel per cycle while the receiver does not stall: the
// front multiplies, a two-entry queue follows, then the back adds, scales
// by a reciprocal multiply and clamps in three register stages.
// Up to six pixels are held inside; when the receiver stalls, the pipeline
// fills and in_ready_o drops once all six places are taken.
// Reset empties the pipeline and loads the identity matrix. The user writes
// rows through cfg_we_i / cfg_index_i / cfg_data_i while the block is idle;
// the block does not enforce this. An index above the last row is ignored.
// ----------------------------------------------------------------------------
module rgb_color_matrix_clamp_unit
  import rgbcc_pkg::*;
#(
  parameter int unsigned COEFFICIENT_BITS = COEF_BITS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pixel_in_t           in_pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pixel_out_t          out_pixel_o,
  input  logic                cfg_we_i,
  input  cfg_index_t          cfg_index_i,
  input  logic [REG_BITS-1:0] cfg_data_i
);

  localparam int unsigned PROD_BITS = COEFFICIENT_BITS + CHANNEL_BITS + 1;
  localparam int unsigned DATA_BITS = NUM_ROWS * NUM_COLS * PROD_BITS;
  localparam int unsigned EXT_BITS  = 64;

  // Unity gain in the diagonal slot of a row, cut to the register width.
  function automatic logic [REG_BITS-1:0] unity_row(input int unsigned slot);
    logic [EXT_BITS-1:0] v;
    v = EXT_BITS'(UNITY_GAIN) << (slot * COEFFICIENT_BITS);
    return v[REG_BITS-1:0];
  endfunction

  logic [REG_BITS-1:0]  row_q [NUM_ROWS];
  logic                 push_valid;
  logic                 push_ready;
  logic [DATA_BITS-1:0] push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [DATA_BITS-1:0] pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= unity_row(0);
      row_q[1] <= unity_row(1);
      row_q[2] <= unity_row(2);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        IDX_RED_ROW:   row_q[0] <= cfg_data_i;
        IDX_GREEN_ROW: row_q[1] <= cfg_data_i;
        IDX_BLUE_ROW:  row_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rgbcc_front #(
    .COEF_BITS (COEFFICIENT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_pixel_i   (in_pixel_i),
    .row_coef_i   (row_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rgbcc_queue #(
    .WIDTH (DATA_BITS)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rgbcc_back #(
    .COEF_BITS (COEFFICIENT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o)
  );

endmodule

@@ hdl/rgbcc_front.sv @@
// ----------------------------------------------------------------------------
// rgbcc_front
// Accepts pixels and registers the nine coefficient-by-channel products.
// ----------------------------------------------------------------------------
module rgbcc_front
  import rgbcc_pkg::*;
#(
  parameter int unsigned COEF_BITS = COEF_BITS_DEFAULT,
  localparam int unsigned PROD_BITS = COEF_BITS + CHANNEL_BITS + 1,
  localparam int unsigned DATA_BITS = NUM_ROWS * NUM_COLS * PROD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pixel_in_t            in_pixel_i,
  input  logic [REG_BITS-1:0]  row_coef_i [NUM_ROWS],
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output logic [DATA_BITS-1:0] push_data_o
);

  localparam int unsigned EXT_BITS =
    (NUM_COLS * COEF_BITS > REG_BITS) ? NUM_COLS * COEF_BITS : REG_BITS;
  localparam int unsigned NUM_PROD = NUM_ROWS * NUM_COLS;

  logic [CHANNEL_BITS-1:0]     chan [NUM_COLS];
  logic signed [PROD_BITS-1:0] prod_d [NUM_PROD];
  logic signed [PROD_BITS-1:0] prod_q [NUM_PROD];
  logic                        valid_q;

  assign chan[0] = in_pixel_i.red_in;
  assign chan[1] = in_pixel_i.green_in;
  assign chan[2] = in_pixel_i.blue_in;

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    // Coefficient bits above the register read as zero.
    logic [EXT_BITS-1:0] row_ext;
    assign row_ext = EXT_BITS'(row_coef_i[r]);
    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      logic signed [COEF_BITS-1:0]  coef;
      logic signed [CHANNEL_BITS:0] chan_s;
      assign coef   = $signed(row_ext[c*COEF_BITS +: COEF_BITS]);
      assign chan_s = $signed({1'b0, chan[c]});
      assign prod_d[r*NUM_COLS+c] = PROD_BITS'(coef) * PROD_BITS'(chan_s);
    end
  end

  assign in_ready_o   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_PROD; i++) begin
      push_data_o[i*PROD_BITS +: PROD_BITS] = prod_q[i];
    end
  end

endmodule

@@ hdl/rgbcc_queue.sv @@
// ----------------------------------------------------------------------------
// rgbcc_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module rgbcc_queue
  import rgbcc_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam logic [1:0] DEPTH = 2'd2;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != DEPTH);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/rgbcc_back.sv @@
// ----------------------------------------------------------------------------
// rgbcc_back
// Sums each row, divides by unity gain and clamps; three-stage pipeline.
// ----------------------------------------------------------------------------
module rgbcc_back
  import rgbcc_pkg::*;
#(
  parameter int unsigned COEF_BITS = COEF_BITS_DEFAULT,
  localparam int unsigned PROD_BITS = COEF_BITS + CHANNEL_BITS + 1,
  localparam int unsigned DATA_BITS = NUM_ROWS * NUM_COLS * PROD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  logic [DATA_BITS-1:0] pop_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pixel_out_t           out_pixel_o
);

  localparam int unsigned SUM_BITS = PROD_BITS + 2;

  logic signed [SUM_BITS-1:0] sum_d [NUM_ROWS];
  logic signed [SUM_BITS-1:0] sum_q [NUM_ROWS];
  logic                       neg_d [NUM_ROWS];
  logic                       neg_q [NUM_ROWS];
  logic                       big_d [NUM_ROWS];
  logic                       big_q [NUM_ROWS];
  logic [SCALED_BITS-1:0]     scaled_d [NUM_ROWS];
  logic [SCALED_BITS-1:0]     scaled_q [NUM_ROWS];
  logic [CHANNEL_BITS-1:0]    chan_d [NUM_ROWS];
  pixel_out_t                 pixel_q;

  logic sum_valid_q;
  logic div_valid_q;
  logic out_valid_q;
  logic out_load;
  logic div_load;
  logic sum_load;

  // A stage loads when it is empty or its content moves on this cycle.
  assign out_load    = !out_valid_q || out_ready_i;
  assign div_load    = !div_valid_q || out_load;
  assign sum_load    = !sum_valid_q || div_load;
  assign pop_ready_o = sum_load;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum_d[r] = '0;
      for (int c = 0; c < NUM_COLS; c++) begin
        sum_d[r] = sum_d[r] + SUM_BITS'($signed(
                     pop_data_i[(r*NUM_COLS+c)*PROD_BITS +: PROD_BITS]));
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      neg_d[r]    = sum_q[r][SUM_BITS-1];
      big_d[r]    = (sum_q[r] >= $signed(SUM_BITS'(CLAMP_LIMIT)));
      scaled_d[r] = SCALED_BITS'(sum_q[r][DIV_IN_BITS-1:0]) * SCALED_BITS'(RECIP_MULT);
    end
  end

  // Negative sums truncate to zero or below, so they all clamp to zero.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      priority if (neg_q[r]) begin
        chan_d[r] = '0;
      end else if (big_q[r]) begin
        chan_d[r] = CHANNEL_BITS'(CHANNEL_MAX);
      end else begin
        chan_d[r] = scaled_q[r][RECIP_SHIFT +: CHANNEL_BITS];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      div_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sum_load) begin
        sum_valid_q <= pop_valid_i;
      end
      if (div_load) begin
        div_valid_q <= sum_valid_q;
      end
      if (out_load) begin
        out_valid_q <= div_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_load && pop_valid_i) begin
      sum_q <= sum_d;
    end
    if (div_load && sum_valid_q) begin
      neg_q    <= neg_d;
      big_q    <= big_d;
      scaled_q <= scaled_d;
    end
    if (out_load && div_valid_q) begin
      pixel_q.red_out   <= chan_d[0];
      pixel_q.green_out <= chan_d[1];
      pixel_q.blue_out  <= chan_d[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = pixel_q;

endmodule

@@ hdl/rgbcc_checker.sv @@
// ----------------------------------------------------------------------------
// rgbcc_checker
// Port-level checks of the color matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
module rgbcc_checker
  import rgbcc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input pixel_out_t out_pixel_o
);

  localparam logic [3:0] MAX_IN_FLIGHT = 4'd6;

  logic       in_xfer;
  logic       out_xfer;
  logic [3:0] occ_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Track pixels taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + 4'(in_xfer) - 4'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_pixel_o))
    else $error("out_pixel_o changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != 4'd0)
    else $error("result shown with no pixel in flight");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= MAX_IN_FLIGHT)
    else $error("more pixels in flight than the pipeline holds");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == 4'd0 |-> in_ready_o)
    else $error("empty block refuses input");

endmodule

bind rgb_color_matrix_clamp_unit rgbcc_checker u_checker (.*);

@@ test/rgb_color_matrix_clamp_unit_tb.sv @@
// ----------------------------------------------------------------------------
// rgb_color_matrix_clamp_unit_tb
// Self-checking testbench of the RGB color matrix and clamp unit.
// ----------------------------------------------------------------------------
// Drives pixels through the in channel and checks every pixel on the out
// channel against a color matrix predictor held in a small scoreboard.
// The rows are reloaded between phases while the pipeline is empty: first
// directed corner cases (identity, saturating gains, negative gains,
// truncation around 1000, ignored row index), then random phases with
// bursty input traffic and a receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------
module rgb_color_matrix_clamp_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbcc_pkg::*;

  localparam int unsigned CB = COEF_BITS_DEFAULT;
  localparam cfg_index_t IDX_UNUSED = 2'd3;

  class pixel_scoreboard;
    logic [REG_BITS-1:0] rows [NUM_ROWS];
    pixel_out_t          expected_q [$];
    int                  errors;

    function new();
      errors = 0;
      rows[IDX_RED_ROW]   = REG_BITS'(UNITY_GAIN);
      rows[IDX_GREEN_ROW] = REG_BITS'(UNITY_GAIN) << CB;
      rows[IDX_BLUE_ROW]  = REG_BITS'(UNITY_GAIN) << (2 * CB);
    endfunction

    function void write_row(cfg_index_t idx, logic [REG_BITS-1:0] value);
      // Indexes above the blue row are dropped by the block.
      if (idx <= IDX_BLUE_ROW) begin
        rows[idx] = value;
      end
    endfunction

    function longint coef(logic [REG_BITS-1:0] row, int slot);
      logic signed [CB-1:0] c;
      c = row[slot*CB +: CB];
      return longint'(c);
    endfunction

    function logic [CHANNEL_BITS-1:0] corrected(logic [REG_BITS-1:0] row, pixel_in_t p);
      longint acc;
      longint q;
      acc = coef(row, 0) * longint'(p.red_in) + coef(row, 1) * longint'(p.green_in)
          + coef(row, 2) * longint'(p.blue_in);
      // Signed division truncates toward zero, as required.
      q = acc / longint'(UNITY_GAIN);
      if (q > longint'(CHANNEL_MAX)) begin
        q = longint'(CHANNEL_MAX);
      end else if (q < 0) begin
        q = 0;
      end
      return q[CHANNEL_BITS-1:0];
    endfunction

    function void note_pixel(pixel_in_t p);
      pixel_out_t e;
      e.red_out   = corrected(rows[IDX_RED_ROW], p);
      e.green_out = corrected(rows[IDX_GREEN_ROW], p);
      e.blue_out  = corrected(rows[IDX_BLUE_ROW], p);
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [CHANNEL_BITS-1:0] want,
                                logic [CHANNEL_BITS-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_pixel(pixel_out_t got);
      pixel_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: output pixel with nothing expected, expected none actual %h",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("red_out", want.red_out, got.red_out);
      compare_field("green_out", want.green_out, got.green_out);
      compare_field("blue_out", want.blue_out, got.blue_out);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  pixel_in_t           in_pixel_i;
  logic                out_valid_o;
  logic                out_ready_i;
  pixel_out_t          out_pixel_o;
  logic                cfg_we_i;
  cfg_index_t          cfg_index_i;
  logic [REG_BITS-1:0] cfg_data_i;

  pixel_scoreboard sb = new();
  int              hold_request = 0;

  rgb_color_matrix_clamp_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_pixel(in_pixel_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_pixel(out_pixel_o);
    end
  end

  // Receiver: segments of random style and length, plus a requested hold-off.
  initial begin
    int style;
    int seg_len;
    int hold_left;
    int tick;
    hold_left = 0;
    tick = 0;
    out_ready_i = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      seg_len = $urandom_range(1, 40);
      repeat (seg_len) begin
        @(negedge clk_i);
        tick++;
        if (hold_request > 0) begin
          hold_left = hold_request;
          hold_request = 0;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready_i <= 1'b0;
        end else begin
          case (style)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= 1'($urandom_range(0, 1));
            2: out_ready_i <= ($urandom_range(0, 3) == 0);
            default: out_ready_i <= (tick % 3 != 0);
          endcase
        end
      end
    end
  end

  task automatic send_pixel(pixel_in_t p, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_rgb(int r, int g, int b);
    pixel_in_t p;
    p.red_in   = r[CHANNEL_BITS-1:0];
    p.green_in = g[CHANNEL_BITS-1:0];
    p.blue_in  = b[CHANNEL_BITS-1:0];
    send_pixel(p, $urandom_range(0, 2));
  endtask

  // Drop valid and wait until the pipeline has drained.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_row(cfg_index_t idx, logic [REG_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    sb.write_row(idx, value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [REG_BITS-1:0] pack_row(int cr, int cg, int cb);
    return {cb[CB-1:0], cg[CB-1:0], cr[CB-1:0]};
  endfunction

  task automatic load_matrix(logic [REG_BITS-1:0] r0, logic [REG_BITS-1:0] r1,
                             logic [REG_BITS-1:0] r2);
    write_row(IDX_RED_ROW, r0);
    write_row(IDX_GREEN_ROW, r1);
    write_row(IDX_BLUE_ROW, r2);
  endtask

  function automatic logic [REG_BITS-1:0] random_row(int diag);
    int style;
    int c [3];
    style = $urandom_range(0, 9);
    if (style < 5) begin
      // Near-identity gains keep most outputs off the clamp.
      for (int k = 0; k < 3; k++) begin
        c[k] = (k == diag) ? int'($urandom_range(500, 1800))
                           : int'($urandom_range(0, 1000)) - 500;
      end
      return pack_row(c[0], c[1], c[2]);
    end else if (style < 7) begin
      for (int k = 0; k < 3; k++) begin
        c[k] = int'($urandom_range(0, 2400)) - 1200;
      end
      return pack_row(c[0], c[1], c[2]);
    end else if (style < 9) begin
      return REG_BITS'({$urandom, $urandom});
    end else begin
      case ($urandom_range(0, 2))
        0: return pack_row(32767, 32767, 32767);
        1: return pack_row(-32768, -32768, -32768);
        default: return '0;
      endcase
    end
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] random_channel();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      default: return CHANNEL_BITS'($urandom_range(0, CHANNEL_MAX));
    endcase
  endfunction

  task automatic run_pixels(int count, bit squeeze);
    pixel_in_t p;
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == count / 2) begin
        // Hold the receiver off and keep offering so the input stalls.
        hold_request = 120;
        for (int k = 0; k < 40; k++) begin
          p.red_in   = random_channel();
          p.green_in = random_channel();
          p.blue_in  = random_channel();
          send_pixel(p, 0);
        end
      end
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 24);
        gap = $urandom_range(1, 8);
      end else begin
        gap = 0;
      end
      burst_left--;
      p.red_in   = random_channel();
      p.green_in = random_channel();
      p.blue_in  = random_channel();
      send_pixel(p, gap);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_pixel_i  = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = IDX_RED_ROW;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Identity after reset, channel extremes.
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(1, 128, 254);
    send_rgb(255, 0, 128);
    settle();

    // Write to an unused index; identity must remain.
    write_row(IDX_UNUSED, REG_BITS'({$urandom, $urandom}));
    send_rgb(17, 200, 99);
    send_rgb(0, 255, 0);
    settle();

    // Largest positive gains saturate high.
    load_matrix(pack_row(32767, 32767, 32767), pack_row(32767, 32767, 32767),
                pack_row(32767, 32767, 32767));
    send_rgb(255, 255, 255);
    send_rgb(0, 0, 0);
    send_rgb(1, 0, 0);
    settle();

    // Most negative gains clamp to zero.
    load_matrix(pack_row(-32768, -32768, -32768), pack_row(-32768, -32768, -32768),
                pack_row(-32768, -32768, -32768));
    send_rgb(255, 255, 255);
    send_rgb(0, 0, 1);
    settle();

    // Truncation around one unit of gain and the top edge of the clamp.
    load_matrix(pack_row(1000, -1, 0), pack_row(-1000, 1, 0), pack_row(0, 0, 1004));
    send_rgb(1, 1, 254);
    send_rgb(2, 1, 255);
    send_rgb(1, 0, 253);
    send_rgb(255, 255, 0);
    settle();

    for (int phase = 0; phase < 14; phase++) begin
      load_matrix(random_row(0), random_row(1), random_row(2));
      if ($urandom_range(0, 3) == 0) begin
        write_row(IDX_UNUSED, REG_BITS'({$urandom, $urandom}));
      end
      run_pixels($urandom_range(100, 160), phase == 5 || phase == 11);
      settle();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
